[rtl/brsm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brsm_pkg
// Types and constants shared by the block range add / range sum blocks.
// ----------------------------------------------------------------------------
package brsm_pkg;

    localparam int IDX_W  = 11;
    localparam int BS_W   = 6;
    localparam int DATA_W = 64;

    // input mode codes
    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_ADD   = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    // configuration register indexes
    localparam logic CFG_ELEM_COUNT = 1'b0;
    localparam logic CFG_BLOCK_SIZE = 1'b1;

    localparam logic [IDX_W-1:0] RST_ELEM_COUNT = 11'd1024;
    localparam logic [BS_W-1:0]  RST_BLOCK_SIZE = 6'd32;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_ADD,
        OP_QUERY,
        OP_ERR
    } t_op;

    typedef struct packed {
        logic [1:0]              mode;
        logic [IDX_W-1:0]        first_index;
        logic [IDX_W-1:0]        last_index;
        logic signed [DATA_W-1:0] amount;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] range_sum;
        logic                     error;
    } t_out;

    // decoded command handed from the front to the back
    typedef struct packed {
        t_op               op;
        logic [IDX_W-1:0]  lo;
        logic [IDX_W-1:0]  hi;
        logic [IDX_W-1:0]  first_end;
        logic [IDX_W-1:0]  last_start;
        logic [IDX_W-1:0]  sb;
        logic [IDX_W-1:0]  eb;
        logic [BS_W-1:0]   bs;
        logic [DATA_W-1:0] amount;
    } t_cmd;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_DIV,
        FR_PUSH
    } t_fr_state;

    typedef enum logic [3:0] {
        BK_CLR,
        BK_IDLE,
        BK_LD_RD,
        BK_LD_WR,
        BK_SEG_RD,
        BK_SEG_LD,
        BK_EL_RD,
        BK_EL_OP,
        BK_EL_DIV,
        BK_SEG_END,
        BK_MID_RD,
        BK_MID_OP,
        BK_MID_DIV,
        BK_RES
    } t_bk_state;

endpackage

[rtl/block_range_add_range_sum_mod_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_range_add_range_sum_mod_top
// Range add / range sum modulo over a blocked array with lazy block tags.
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  in        input      i_in_valid/o_in_ready   i_in  (t_in)
//  out       output     o_out_valid/i_out_ready o_out (t_out)
//  cfg       input      i_cfg_we                i_cfg_idx, i_cfg_data
//
//  The front takes no new item until the last is through its 11-step block
//  number division and pushed. Back: a load reads, then writes; an add updates
//  each partial element and middle block; a query runs the 64-step remainder
//  per element or middle block. After reset the tag and sum memories are
//  cleared and no item is taken meanwhile. A full queue stalls the front, a
//  waiting result stalls the back only when it has the next result ready.
// ----------------------------------------------------------------------------
module block_range_add_range_sum_mod_top
    import brsm_pkg::*;
#(
    parameter int MAX_ELEMS   = 1024,
    parameter int MAX_BLOCKS  = 64,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in              i_in,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out             o_out,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [IDX_W-1:0] i_cfg_data
);

    logic [IDX_W-1:0] r_elem_count;
    logic [BS_W-1:0]  r_block_size;
    logic [BS_W-1:0]  bs_eff;
    logic             init_done;
    logic             q_full;
    logic             q_valid;
    logic             push;
    logic             pop;
    t_cmd             push_cmd;
    t_cmd             pop_cmd;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elem_count <= RST_ELEM_COUNT;
            r_block_size <= RST_BLOCK_SIZE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ELEM_COUNT: r_elem_count <= i_cfg_data;
                default:        r_block_size <= i_cfg_data[BS_W-1:0];
            endcase
        end
    end

    // block size zero acts as one
    assign bs_eff = (r_block_size == '0) ? BS_W'(1) : r_block_size;

    brsm_front #(
        .MAX_ELEMS  (MAX_ELEMS),
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in         (i_in),
        .i_elem_count (r_elem_count),
        .i_block_size (bs_eff),
        .i_init_done  (init_done),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    brsm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (pop_cmd)
    );

    brsm_back #(
        .MAX_ELEMS  (MAX_ELEMS),
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_cmd       (pop_cmd),
        .o_pop       (pop),
        .o_init_done (init_done),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

`ifndef SYNTHESIS
    // never push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && q_full))
        else $error("command pushed into full queue");

    // no item taken during the clearing pass
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !init_done |-> !o_in_ready)
        else $error("item accepted before memories cleared");

    // an error result carries a zero sum
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.error) |-> (o_out.range_sum == '0))
        else $error("error result with nonzero sum");

    // pop only when the queue holds a command
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_valid)
        else $error("pop from empty queue");
`endif

endmodule

[rtl/brsm_rem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brsm_rem
// Truncating signed remainder, one restoring step per cycle.
// ----------------------------------------------------------------------------
module brsm_rem
    import brsm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DATA_W-1:0] i_x,
    input  logic [DATA_W-1:0] i_m,
    output logic              o_done,
    output logic [DATA_W-1:0] o_res
);

    localparam int CNT_W = $clog2(DATA_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_W - 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DATA_W-1:0] r_q;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_m;
    logic              r_neg;

    logic [DATA_W-1:0] cat;
    logic              ge;

    // remainder stays below the modulus, so the shifted value fits
    assign cat = {r_rem[DATA_W-2:0], r_q[DATA_W-1]};
    assign ge  = (cat >= r_m);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_LAST);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_x[DATA_W-1];
            r_q   <= i_x[DATA_W-1] ? (~i_x + 1'b1) : i_x;
            r_rem <= '0;
            r_m   <= i_m;
        end else if (r_busy) begin
            r_rem <= ge ? (cat - r_m) : cat;
            r_q   <= {r_q[DATA_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_res  = r_neg ? (~r_rem + 1'b1) : r_rem;

endmodule

[rtl/brsm_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brsm_queue
// Short command queue between the decode front and the execute back.
// ----------------------------------------------------------------------------
module brsm_queue
    import brsm_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];

endmodule

[rtl/brsm_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brsm_front
// Accepts items, finds block numbers by serial division and checks ranges.
// ----------------------------------------------------------------------------
module brsm_front
    import brsm_pkg::*;
#(
    parameter int MAX_ELEMS  = 1024,
    parameter int MAX_BLOCKS = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in              i_in,
    input  logic [IDX_W-1:0] i_elem_count,
    input  logic [BS_W-1:0]  i_block_size,
    input  logic             i_init_done,
    input  logic             i_q_full,
    output logic             o_push,
    output t_cmd             o_cmd
);

    localparam logic [3:0] DIV_LAST = 4'(IDX_W - 1);

    t_fr_state        r_state;
    t_fr_state        n_state;
    t_in              r_in;
    logic [IDX_W-1:0] r_dl;
    logic [IDX_W-1:0] r_dh;
    logic [BS_W-1:0]  r_rl;
    logic [BS_W-1:0]  r_rh;
    logic [3:0]       r_cnt;

    logic             accept;
    logic [IDX_W-1:0] in_hi;
    logic [BS_W:0]    tl;
    logic [BS_W:0]    th;
    logic             gel;
    logic             geh;
    logic [BS_W:0]    nrl;
    logic [BS_W:0]    nrh;
    logic [IDX_W-1:0] hi;
    logic             bad;

    assign accept = i_in_valid && o_in_ready;
    assign in_hi  = (i_in.mode == MODE_LOAD) ? i_in.first_index : i_in.last_index;

    // one restoring division step for each end of the range
    assign tl  = {r_rl, r_dl[IDX_W-1]};
    assign th  = {r_rh, r_dh[IDX_W-1]};
    assign gel = (tl >= {1'b0, i_block_size});
    assign geh = (th >= {1'b0, i_block_size});
    assign nrl = gel ? (tl - {1'b0, i_block_size}) : tl;
    assign nrh = geh ? (th - {1'b0, i_block_size}) : th;

    // range check and command build
    assign hi  = (r_in.mode == MODE_LOAD) ? r_in.first_index : r_in.last_index;
    assign bad = (r_in.first_index == '0) || (hi < r_in.first_index)
              || (hi > i_elem_count) || (32'(hi) > MAX_ELEMS)
              || (32'(r_dh) >= MAX_BLOCKS)
              || ((r_in.mode == MODE_QUERY) && r_in.amount[DATA_W-1]);

    always_comb begin
        o_cmd.lo         = r_in.first_index;
        o_cmd.hi         = hi;
        o_cmd.first_end  = r_in.first_index
                         + IDX_W'(i_block_size - 1'b1 - r_rl);
        o_cmd.last_start = hi - IDX_W'(r_rh);
        o_cmd.sb         = r_dl;
        o_cmd.eb         = r_dh;
        o_cmd.bs         = i_block_size;
        o_cmd.amount     = r_in.amount;
        if (bad) begin
            o_cmd.op = OP_ERR;
        end else begin
            unique case (r_in.mode)
                MODE_LOAD:  o_cmd.op = OP_LOAD;
                MODE_ADD:   o_cmd.op = OP_ADD;
                default:    o_cmd.op = OP_QUERY;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            FR_IDLE: begin
                if (accept) n_state = FR_DIV;
            end
            FR_DIV: begin
                if (r_cnt == DIV_LAST) n_state = FR_PUSH;
            end
            FR_PUSH: begin
                if (r_in.mode == MODE_NONE || !i_q_full) n_state = FR_IDLE;
            end
            default: n_state = FR_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready = (r_state == FR_IDLE) && i_init_done;
        o_push     = (r_state == FR_PUSH) && (r_in.mode != MODE_NONE) && !i_q_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FR_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // divider registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in  <= i_in;
            r_dl  <= i_in.first_index - 1'b1;
            r_dh  <= in_hi - 1'b1;
            r_rl  <= '0;
            r_rh  <= '0;
            r_cnt <= '0;
        end else if (r_state == FR_DIV) begin
            r_dl  <= {r_dl[IDX_W-2:0], gel};
            r_dh  <= {r_dh[IDX_W-2:0], geh};
            r_rl  <= nrl[BS_W-1:0];
            r_rh  <= nrh[BS_W-1:0];
            r_cnt <= r_cnt + 1'b1;
        end
    end

endmodule

[rtl/brsm_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brsm_back
// Executes commands over the element store and per-block tag and sum memories.
// ----------------------------------------------------------------------------
module brsm_back
    import brsm_pkg::*;
#(
    parameter int MAX_ELEMS  = 1024,
    parameter int MAX_BLOCKS = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_valid,
    input  t_cmd i_cmd,
    output logic o_pop,
    output logic o_init_done,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    localparam int AW = $clog2(MAX_ELEMS);
    localparam int BW = $clog2(MAX_BLOCKS);
    localparam logic [BW-1:0] CLR_LAST = BW'(MAX_BLOCKS - 1);

    logic [DATA_W-1:0] r_elem_mem [MAX_ELEMS];
    logic [DATA_W-1:0] r_tag_mem  [MAX_BLOCKS];
    logic [DATA_W-1:0] r_sum_mem  [MAX_BLOCKS];
    logic [DATA_W-1:0] r_elem_q;
    logic [DATA_W-1:0] r_tag_q;
    logic [DATA_W-1:0] r_sum_q;

    t_bk_state         r_state;
    t_bk_state         n_state;
    t_cmd              r_cmd;
    logic [BW-1:0]     r_clr;
    logic [IDX_W-1:0]  r_i;
    logic [IDX_W-1:0]  r_seg_hi;
    logic [IDX_W-1:0]  r_blk;
    logic [DATA_W-1:0] r_acc;
    logic [DATA_W-1:0] r_bsum;
    logic [DATA_W-1:0] r_tag;
    logic [DATA_W-1:0] r_mod;
    logic [DATA_W-1:0] r_vbs;
    logic              r_out_valid;
    t_out              r_out;

    logic [AW-1:0]     elem_addr;
    logic [BW-1:0]     blk_addr;
    logic              elem_we;
    logic [DATA_W-1:0] elem_wdata;
    logic              tag_we;
    logic [DATA_W-1:0] tag_wdata;
    logic              sum_we;
    logic [DATA_W-1:0] sum_wdata;
    logic              rem_start;
    logic [DATA_W-1:0] rem_x;
    logic              rem_done;
    logic [DATA_W-1:0] rem_res;
    logic              is_add;
    logic              el_last;
    logic              mid_last;
    logic              seg_done;
    logic              res_go;

    brsm_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (rem_start),
        .i_x     (rem_x),
        .i_m     (r_mod),
        .o_done  (rem_done),
        .o_res   (rem_res)
    );

    assign is_add    = (r_cmd.op == OP_ADD);
    assign el_last   = (r_i == r_seg_hi);
    assign mid_last  = ((r_blk + 1'b1) == r_cmd.eb);
    assign seg_done  = (r_blk == r_cmd.eb);
    assign res_go    = !r_out_valid || i_out_ready;
    assign elem_addr = AW'(r_i - 1'b1);
    assign blk_addr  = (r_state == BK_CLR) ? r_clr : BW'(r_blk);

    // memories
    always_ff @(posedge i_clk) begin
        if (elem_we) r_elem_mem[elem_addr] <= elem_wdata;
        if (tag_we)  r_tag_mem[blk_addr]   <= tag_wdata;
        if (sum_we)  r_sum_mem[blk_addr]   <= sum_wdata;
        r_elem_q <= r_elem_mem[elem_addr];
        r_tag_q  <= r_tag_mem[blk_addr];
        r_sum_q  <= r_sum_mem[blk_addr];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_CLR:    if (r_clr == CLR_LAST) n_state = BK_IDLE;
            BK_IDLE: begin
                if (i_q_valid) begin
                    unique case (i_cmd.op)
                        OP_LOAD: n_state = BK_LD_RD;
                        OP_ERR:  n_state = BK_RES;
                        default: n_state = BK_SEG_RD;
                    endcase
                end
            end
            BK_LD_RD:  n_state = BK_LD_WR;
            BK_LD_WR:  n_state = BK_IDLE;
            BK_SEG_RD: n_state = BK_SEG_LD;
            BK_SEG_LD: n_state = BK_EL_RD;
            BK_EL_RD:  n_state = BK_EL_OP;
            BK_EL_OP: begin
                if (!is_add)      n_state = BK_EL_DIV;
                else if (el_last) n_state = BK_SEG_END;
                else              n_state = BK_EL_RD;
            end
            BK_EL_DIV: begin
                if (rem_done) n_state = el_last ? BK_SEG_END : BK_EL_RD;
            end
            BK_SEG_END: begin
                if (seg_done)                       n_state = is_add ? BK_IDLE : BK_RES;
                else if (r_cmd.sb + 1'b1 == r_cmd.eb) n_state = BK_SEG_RD;
                else                                n_state = BK_MID_RD;
            end
            BK_MID_RD: n_state = BK_MID_OP;
            BK_MID_OP: begin
                if (!is_add)       n_state = BK_MID_DIV;
                else if (mid_last) n_state = BK_SEG_RD;
                else               n_state = BK_MID_RD;
            end
            BK_MID_DIV: begin
                if (rem_done) n_state = mid_last ? BK_SEG_RD : BK_MID_RD;
            end
            BK_RES:    if (res_go) n_state = BK_IDLE;
            default:   n_state = BK_IDLE;
        endcase
    end

    // memory and divider controls
    always_comb begin
        elem_we    = 1'b0;
        elem_wdata = r_elem_q + r_cmd.amount;
        tag_we     = 1'b0;
        tag_wdata  = r_tag_q + r_cmd.amount;
        sum_we     = 1'b0;
        sum_wdata  = r_bsum;
        rem_start  = 1'b0;
        rem_x      = r_acc + r_tag + r_elem_q;
        o_pop      = (r_state == BK_IDLE) && i_q_valid;
        unique case (r_state)
            BK_CLR: begin
                tag_we    = 1'b1;
                tag_wdata = '0;
                sum_we    = 1'b1;
                sum_wdata = '0;
            end
            BK_LD_WR: begin
                elem_we    = 1'b1;
                elem_wdata = r_cmd.amount;
                sum_we     = 1'b1;
                sum_wdata  = r_sum_q + r_cmd.amount;
            end
            BK_EL_OP: begin
                elem_we   = is_add;
                rem_start = !is_add;
            end
            BK_SEG_END: begin
                sum_we = is_add;
            end
            BK_MID_OP: begin
                tag_we    = is_add;
                sum_we    = is_add;
                sum_wdata = r_sum_q + r_vbs;
                rem_start = !is_add;
                rem_x     = r_acc + r_sum_q;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_CLR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == BK_CLR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (r_state == BK_RES && res_go) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // sequencer datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            BK_IDLE: begin
                if (i_q_valid) begin
                    r_cmd    <= i_cmd;
                    r_i      <= i_cmd.lo;
                    r_blk    <= i_cmd.sb;
                    r_seg_hi <= (i_cmd.sb == i_cmd.eb) ? i_cmd.hi : i_cmd.first_end;
                    r_acc    <= '0;
                    r_mod    <= i_cmd.amount + 1'b1;
                    r_vbs    <= DATA_W'(i_cmd.amount * {{(DATA_W-BS_W){1'b0}}, i_cmd.bs});
                end
            end
            BK_SEG_LD: begin
                r_tag  <= r_tag_q;
                r_bsum <= r_sum_q;
            end
            BK_EL_OP: begin
                if (is_add) begin
                    r_bsum <= r_bsum + r_cmd.amount;
                    if (!el_last) r_i <= r_i + 1'b1;
                end
            end
            BK_EL_DIV: begin
                if (rem_done) begin
                    r_acc <= rem_res;
                    if (!el_last) r_i <= r_i + 1'b1;
                end
            end
            BK_SEG_END: begin
                if (!seg_done) begin
                    if (r_cmd.sb + 1'b1 == r_cmd.eb) begin
                        r_i      <= r_cmd.last_start;
                        r_seg_hi <= r_cmd.hi;
                        r_blk    <= r_cmd.eb;
                    end else begin
                        r_blk <= r_blk + 1'b1;
                    end
                end
            end
            BK_MID_OP, BK_MID_DIV: begin
                if ((r_state == BK_MID_OP && is_add) || (r_state == BK_MID_DIV && rem_done)) begin
                    if (r_state == BK_MID_DIV) r_acc <= rem_res;
                    if (mid_last) begin
                        r_i      <= r_cmd.last_start;
                        r_seg_hi <= r_cmd.hi;
                        r_blk    <= r_cmd.eb;
                    end else begin
                        r_blk <= r_blk + 1'b1;
                    end
                end
            end
            BK_RES: begin
                if (res_go) begin
                    r_out.error     <= (r_cmd.op == OP_ERR);
                    r_out.range_sum <= (r_cmd.op == OP_ERR) ? '0 : r_acc;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_init_done = (r_state != BK_CLR);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
